@@ rtl/core/record_table_with_sort_top_defines.svh @@
// Assertion macros for the record table block
`ifndef RECORD_TABLE_WITH_SORT_TOP_DEFINES_SVH
`define RECORD_TABLE_WITH_SORT_TOP_DEFINES_SVH
// implication checked on every rising clock edge out of reset
`define RTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define RTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/core/rts_pkg.sv @@
// Package: shared constants and types of the record table
`default_nettype none
package rts_pkg;
	localparam int DEF_ENTRIES = 16;
	localparam int REC_W = 96;
	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_MODIFY = 3'd1;
	localparam logic [2:0] ACT_DELETE = 3'd2;
	localparam logic [2:0] ACT_FINDMAX = 3'd3;
	localparam logic [2:0] ACT_SORT = 3'd4;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;
	typedef struct packed {
		logic [31:0] quantity;
		logic [31:0] amount;
		logic [31:0] code;
	} rec_t;
endpackage
`default_nettype wire

@@ rtl/core/rts_ram.sv @@
// Generic single-port-write, single-read RAM with registered read
`default_nettype none
module rts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/record_table_with_sort_top.sv @@
// Top level: record table with searches and descending exchange sort
// Insert: written and answered in S_WAIT. Modify/delete/find-max: one scan of the table,
// a read (S_SCAN) and a compare (S_SCANW) per slot, then S_OUT. Sort: per outer slot,
// read slot i (S_RI), read (S_RJ) and compare (S_CMP) each later slot, write slot i back
// (S_WAIT); then ENTRIES results, each read (S_EMIT) and sent (S_EMITW). One item at a
// time, set by the single RAM read port. Reset clears the count; S_CLR zeroes the RAM.
`default_nettype none
`include "record_table_with_sort_top_defines.svh"
module record_table_with_sort_top import rts_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// action[2:0], key_code[34:3], new_code[66:35], new_amount[98:67],
	// new_quantity[130:99], zero fill
	input  wire [135:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// status[1:0], position[5:2], out_code[37:6], out_amount[69:38],
	// out_quantity[101:70], zero fill
	output logic [103:0] m_tdata,
	output logic        m_tlast
);
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_SCAN = 4'd2, S_SCANW = 4'd3,
		S_RI = 4'd4, S_RJ = 4'd5, S_CMP = 4'd6, S_EMIT = 4'd7, S_EMITW = 4'd8,
		S_OUT = 4'd9, S_WAIT = 4'd10;

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] i_q, j_q, hit_q;
	logic hit_v_q;
	logic [2:0] act_q;
	logic [31:0] key_q;
	rec_t new_q, ri_q, best_q;
	logic we;
	logic [AW-1:0] waddr, raddr;
	rec_t wdata, rdata;

	rts_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [1:0] o_st_q;
	logic [3:0] o_pos_q;
	rec_t o_rec_q;
	logic o_last_q, o_v_q;
	logic [AW-1:0] rd_q;

	assign s_tready = (state_q == S_IDLE) && !o_v_q;
	assign m_tvalid = o_v_q;
	assign m_tlast = o_last_q;
	assign m_tdata = {2'b0, o_rec_q.quantity, o_rec_q.amount, o_rec_q.code, o_pos_q, o_st_q};

	// RAM port control
	always_comb begin
		we = 1'b0;
		waddr = i_q;
		wdata = '0;
		raddr = rd_q;
		case (state_q)
			S_CLR: begin
				we = 1'b1;
			end
			S_CMP: begin
				// swap when amount[j] > amount[i]: write j now, i stays in ri_q
				if ($signed(rdata.amount) > $signed(ri_q.amount)) begin
					we = 1'b1;
					waddr = j_q;
					wdata = ri_q;
				end
			end
			S_WAIT: begin
				we = (act_q != ACT_SORT);
				waddr = (act_q == ACT_INSERT) ? count_q[AW-1:0] : hit_q;
				wdata = new_q;
				if (act_q == ACT_SORT) begin
					we = 1'b1;
					waddr = i_q;
					wdata = ri_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			rd_q <= '0;
			hit_v_q <= 1'b0;
			o_v_q <= 1'b0;
			act_q <= '0;
		end else begin
			if (o_v_q && m_tready) o_v_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					i_q <= i_q + 1'b1;
					if (i_q == LAST_IDX) begin
						state_q <= S_IDLE;
						i_q <= '0;
					end
				end
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						act_q <= s_tdata[2:0];
						key_q <= s_tdata[34:3];
						new_q <= {s_tdata[130:99], s_tdata[98:67], s_tdata[66:35]};
						hit_v_q <= 1'b0;
						best_q <= '0;
						rd_q <= '0;
						i_q <= '0;
						o_pos_q <= '0;
						o_rec_q <= '0;
						o_last_q <= 1'b1;
						case (s_tdata[2:0])
							ACT_INSERT: begin
								if (count_q == CW'(ENTRIES)) begin
									o_st_q <= ST_FULL;
									o_v_q <= 1'b1;
								end else begin
									o_st_q <= ST_OK;
									o_pos_q <= 4'(count_q);
									o_rec_q <= {s_tdata[130:99], s_tdata[98:67],
										s_tdata[66:35]};
									state_q <= S_WAIT;
								end
							end
							ACT_MODIFY, ACT_DELETE, ACT_SORT: begin
								if (count_q == '0) begin
									o_st_q <= ST_EMPTY;
									o_v_q <= 1'b1;
								end else if (s_tdata[2:0] == ACT_SORT) begin
									state_q <= S_RI;
								end else begin
									state_q <= S_SCAN;
								end
							end
							ACT_FINDMAX: begin
								if (count_q == '0) begin
									o_st_q <= ST_NOTFOUND;
									o_v_q <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					// read of slot i issued; data arrives next cycle
					rd_q <= rd_q + 1'b1;
					state_q <= S_SCANW;
				end
				S_SCANW: begin
					if (act_q == ACT_FINDMAX) begin
						if ($signed(rdata.amount) > $signed(best_q.amount)) begin
							best_q <= rdata;
							hit_q <= i_q;
							hit_v_q <= 1'b1;
						end
					end else if (!hit_v_q && rdata.code == key_q) begin
						hit_q <= i_q;
						hit_v_q <= 1'b1;
					end
					i_q <= i_q + 1'b1;
					if (i_q == LAST_IDX) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (!hit_v_q) begin
						o_st_q <= ST_NOTFOUND;
						o_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						o_st_q <= ST_OK;
						o_pos_q <= 4'(hit_q);
						if (act_q == ACT_FINDMAX) begin
							o_rec_q <= best_q;
							o_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (act_q == ACT_DELETE) begin
							new_q <= '1;
							o_rec_q <= '1;
							state_q <= S_WAIT;
						end else begin
							o_rec_q <= new_q;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					// write back (insert/modify/delete) or slot i after sort pass
					if (act_q == ACT_SORT) begin
						if (i_q == LAST_IDX - 1'b1) begin
							rd_q <= '0;
							i_q <= '0;
							state_q <= S_EMIT;
						end else begin
							i_q <= i_q + 1'b1;
							rd_q <= i_q + 1'b1;
							state_q <= S_RI;
						end
					end else begin
						if (act_q == ACT_INSERT) count_q <= count_q + 1'b1;
						o_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RI: begin
					rd_q <= i_q + 1'b1;
					j_q <= i_q + 1'b1;
					state_q <= S_RJ;
				end
				S_RJ: begin
					// first cycle: rdata is slot i
					if (j_q == i_q + 1'b1 && rd_q == j_q) ri_q <= rdata;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ($signed(rdata.amount) > $signed(ri_q.amount)) ri_q <= rdata;
					if (j_q == LAST_IDX) begin
						state_q <= S_WAIT;
					end else begin
						j_q <= j_q + 1'b1;
						rd_q <= j_q + 1'b1;
						state_q <= S_RJ;
					end
				end
				S_EMIT: begin
					if (!o_v_q || m_tready) begin
						rd_q <= rd_q + 1'b1;
						state_q <= S_EMITW;
					end
				end
				S_EMITW: begin
					o_v_q <= 1'b1;
					o_st_q <= ST_OK;
					o_pos_q <= 4'(i_q);
					o_rec_q <= rdata;
					o_last_q <= (i_q == LAST_IDX);
					i_q <= i_q + 1'b1;
					state_q <= (i_q == LAST_IDX) ? S_IDLE : S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RTS_ASSERT_IMP(a_cnt_range, 1'b1, count_q <= CW'(ENTRIES))
	`RTS_ASSERT_IMP(a_no_accept_busy, state_q != S_IDLE, !s_tready)
	`RTS_ASSERT_NEXT(a_insert_grows, state_q == S_WAIT && act_q == ACT_INSERT,
		count_q == $past(count_q) + 1'b1)
	`RTS_ASSERT_IMP(a_emit_ok, o_v_q && !o_last_q, o_st_q == ST_OK)
endmodule
`default_nettype wire

@@ test/record_table_with_sort_top_tb.sv @@
// Testbench for the record table: directed table plus random actions, checked by a predictor
`timescale 1ns / 100ps
`default_nettype none
module record_table_with_sort_top_tb;
	import rts_pkg::*;

	localparam int N_SLOTS = DEF_ENTRIES;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 100;

	typedef struct {
		logic [1:0] status;
		logic [3:0] position;
		logic [31:0] code;
		logic [31:0] amount;
		logic [31:0] quantity;
		logic last;
	} table_result_t;

	typedef struct {
		logic [2:0] action;
		logic [31:0] key;
		logic [31:0] code;
		logic [31:0] amount;
		logic [31:0] quantity;
		bit fixed;
		logic [1:0] fixed_status;
	} table_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic m_tlast;

	logic [31:0] code_mirror [N_SLOTS];
	logic [31:0] amount_mirror [N_SLOTS];
	logic [31:0] quantity_mirror [N_SLOTS];
	int count_mirror;
	table_result_t pending_results [$];
	table_cmd_t directed [$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;

	record_table_with_sort_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	function automatic table_result_t make_result(logic [1:0] st, logic [3:0] pos,
			logic [31:0] c, logic [31:0] a, logic [31:0] q, logic l);
		table_result_t r;
		r.status = st; r.position = pos; r.code = c; r.amount = a; r.quantity = q;
		r.last = l;
		return r;
	endfunction

	// work out the results of one action and update the mirrored table
	task automatic predict_action(input table_cmd_t cmd);
		int hit;
		logic signed [31:0] best;
		logic [31:0] t;
		hit = -1;
		case (cmd.action)
			ACT_INSERT: begin
				if (count_mirror >= N_SLOTS) begin
					pending_results.push_back(make_result(ST_FULL, 0, 0, 0, 0, 1));
				end else begin
					code_mirror[count_mirror] = cmd.code;
					amount_mirror[count_mirror] = cmd.amount;
					quantity_mirror[count_mirror] = cmd.quantity;
					pending_results.push_back(make_result(ST_OK, count_mirror[3:0],
						cmd.code, cmd.amount, cmd.quantity, 1));
					count_mirror++;
				end
			end
			ACT_MODIFY, ACT_DELETE: begin
				if (count_mirror == 0) begin
					pending_results.push_back(make_result(ST_EMPTY, 0, 0, 0, 0, 1));
				end else begin
					for (int i = N_SLOTS - 1; i >= 0; i--)
						if (code_mirror[i] == cmd.key) hit = i;
					if (hit < 0) begin
						pending_results.push_back(make_result(ST_NOTFOUND, 0, 0, 0, 0, 1));
					end else begin
						if (cmd.action == ACT_MODIFY) begin
							code_mirror[hit] = cmd.code;
							amount_mirror[hit] = cmd.amount;
							quantity_mirror[hit] = cmd.quantity;
						end else begin
							code_mirror[hit] = '1;
							amount_mirror[hit] = '1;
							quantity_mirror[hit] = '1;
						end
						pending_results.push_back(make_result(ST_OK, hit[3:0], code_mirror[hit],
							amount_mirror[hit], quantity_mirror[hit], 1));
					end
				end
			end
			ACT_FINDMAX: begin
				best = 0;
				if (count_mirror != 0)
					for (int i = 0; i < N_SLOTS; i++)
						if ($signed(amount_mirror[i]) > best) begin
							best = amount_mirror[i];
							hit = i;
						end
				if (hit < 0)
					pending_results.push_back(make_result(ST_NOTFOUND, 0, 0, 0, 0, 1));
				else
					pending_results.push_back(make_result(ST_OK, hit[3:0], code_mirror[hit],
						amount_mirror[hit], quantity_mirror[hit], 1));
			end
			ACT_SORT: begin
				if (count_mirror == 0) begin
					pending_results.push_back(make_result(ST_EMPTY, 0, 0, 0, 0, 1));
				end else begin
					// exchange sort, descending, same swap order so ties land alike
					for (int i = 0; i < N_SLOTS; i++)
						for (int j = i + 1; j < N_SLOTS; j++)
							if ($signed(amount_mirror[j]) > $signed(amount_mirror[i])) begin
								t = amount_mirror[j]; amount_mirror[j] = amount_mirror[i];
								amount_mirror[i] = t;
								t = code_mirror[j]; code_mirror[j] = code_mirror[i];
								code_mirror[i] = t;
								t = quantity_mirror[j]; quantity_mirror[j] = quantity_mirror[i];
								quantity_mirror[i] = t;
							end
					for (int i = 0; i < N_SLOTS; i++)
						pending_results.push_back(make_result(ST_OK, i[3:0], code_mirror[i],
							amount_mirror[i], quantity_mirror[i], i == N_SLOTS - 1));
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return 32'(int'($urandom_range(0, 20)) - 10);
			default: return $urandom();
		endcase
	endfunction

	function automatic table_cmd_t make_cmd(logic [2:0] act, logic [31:0] k, logic [31:0] c,
			logic [31:0] a, logic [31:0] q);
		table_cmd_t cmd;
		cmd.action = act; cmd.key = k; cmd.code = c; cmd.amount = a; cmd.quantity = q;
		cmd.fixed = 1'b0; cmd.fixed_status = ST_OK;
		return cmd;
	endfunction

	function automatic table_cmd_t make_fixed(logic [2:0] act, logic [1:0] st);
		table_cmd_t cmd;
		cmd = make_cmd(act, 0, 0, 0, 0);
		cmd.fixed = 1'b1; cmd.fixed_status = st;
		return cmd;
	endfunction

	// send one beat with a random gap ahead of it; hold valid high when there is no gap
	task automatic send_beat(input table_cmd_t cmd);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, cmd.quantity, cmd.amount, cmd.code, cmd.key, cmd.action};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_action(cmd);
		if (cmd.fixed) begin
			// status typed in the table must agree with the prediction too
			if (pending_results.size() == 0) begin
				$error("status: expected %0d from table, got no result", cmd.fixed_status);
				fail_count++;
			end else if (pending_results[pending_results.size() - 1].status !=
					cmd.fixed_status) begin
				$error("status: expected %0d from table, got %0d", cmd.fixed_status,
					pending_results[pending_results.size() - 1].status);
				fail_count++;
			end
		end
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if ($urandom_range(0, 19) == 0)
			m_tready <= 1'b0;
		else if ($urandom_range(0, 3) != 0)
			m_tready <= 1'b1;
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		table_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat %h", m_tdata);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[1:0] !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
					fail_count++;
				end
				if (m_tdata[5:2] !== exp_r.position) begin
					$error("position: expected %0d, got %0d", exp_r.position, m_tdata[5:2]);
					fail_count++;
				end
				if (m_tdata[37:6] !== exp_r.code) begin
					$error("out_code: expected %h, got %h", exp_r.code, m_tdata[37:6]);
					fail_count++;
				end
				if (m_tdata[69:38] !== exp_r.amount) begin
					$error("out_amount: expected %h, got %h", exp_r.amount, m_tdata[69:38]);
					fail_count++;
				end
				if (m_tdata[101:70] !== exp_r.quantity) begin
					$error("out_quantity: expected %h, got %h", exp_r.quantity, m_tdata[101:70]);
					fail_count++;
				end
				if (m_tlast !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || stim_done)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("record_table_with_sort_top: mismatch");
			$finish;
		end
	end

	initial begin
		table_cmd_t cmd;
		int wait_cycles;
		for (int i = 0; i < N_SLOTS; i++) begin
			code_mirror[i] = '0; amount_mirror[i] = '0; quantity_mirror[i] = '0;
		end
		count_mirror = 0;

		// directed rows: empty refusals, extremes, fill to full, unused codes, sort
		directed.push_back(make_fixed(ACT_MODIFY, ST_EMPTY));
		directed.push_back(make_fixed(ACT_DELETE, ST_EMPTY));
		directed.push_back(make_fixed(ACT_SORT, ST_EMPTY));
		directed.push_back(make_fixed(ACT_FINDMAX, ST_NOTFOUND));
		directed.push_back(make_cmd(3'd5, '1, '1, '1, '1));
		directed.push_back(make_cmd(ACT_INSERT, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		directed.push_back(make_cmd(ACT_INSERT, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		directed.push_back(make_cmd(ACT_INSERT, 0, '1, '1, '1));
		directed.push_back(make_cmd(ACT_FINDMAX, 0, 0, 0, 0));
		directed.push_back(make_cmd(ACT_MODIFY, '1, 32'd7, 32'd5, 32'd9));
		directed.push_back(make_cmd(ACT_DELETE, 32'h8000_0000, 0, 0, 0));
		directed.push_back(make_cmd(ACT_DELETE, 32'h1234_5678, 0, 0, 0));
		directed.push_back(make_cmd(ACT_MODIFY, 32'd0, 32'd1, 32'd1, 32'd1));
		for (int i = 0; i < 13; i++)
			directed.push_back(make_cmd(ACT_INSERT, 0, i, 32'd50 - i % 3, ~i));
		directed.push_back(make_fixed(ACT_INSERT, ST_FULL));
		directed.push_back(make_cmd(3'd7, 0, 0, 0, 0));
		directed.push_back(make_cmd(ACT_SORT, 0, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_beat(directed[i]);

		// random part: mostly valid keys
		for (int n = 0; n < N_RANDOM; n++) begin
			cmd = make_cmd(3'($urandom_range(0, 4)), rand_word(), rand_word(),
				rand_word(), rand_word());
			if ($urandom_range(0, 29) == 0) cmd.action = 3'($urandom_range(5, 7));
			if ((cmd.action == ACT_MODIFY || cmd.action == ACT_DELETE) &&
					$urandom_range(0, 3) != 0)
				cmd.key = code_mirror[$urandom_range(0, N_SLOTS - 1)];
			if (cmd.action == ACT_SORT && $urandom_range(0, 2) != 0) cmd.action = ACT_FINDMAX;
			send_beat(cmd);
		end
		s_tvalid <= 1'b0;

		// drain, then give the block time to flush anything stray
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		stim_done = 1'b1;
		repeat (500) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("record_table_with_sort_top: match");
		else
			$display("record_table_with_sort_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

@@ record_table_with_sort_top.f @@
+incdir+rtl/core
rtl/core/rts_pkg.sv
rtl/core/rts_ram.sv
rtl/core/record_table_with_sort_top.sv
test/record_table_with_sort_top_tb.sv
